>>> rtl/wfha_pkg.sv
// shared constants, types and codes for the worst-fit heap allocator
`default_nettype none
package wfha_pkg;

   // heap geometry
   localparam int HEAP_DEPTH = 128;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int CHILD_W    = IDX_W + 1;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 32;
   localparam int HDR_W     = 8;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int FREE_W    = 8;
   localparam int ENTRY_W   = ADDR_W + SIZE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_SMALL  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_ISFREE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0] BASE_RESET   = 32'd0;
   localparam logic [SIZE_W-1:0] TOTAL_RESET  = 32'd1048576;
   localparam logic [HDR_W-1:0]  HEADER_RESET = 8'd24;

   // one heap entry
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // configuration registers
   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [SIZE_W-1:0] region_bytes;
      logic [HDR_W-1:0]  header_size;
   } cfg_type;

   // one request item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] user_address;
      logic [SIZE_W-1:0] stored_size;
      logic              was_allocated;
   } req_type;

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   result_address;
      logic [FREE_W-1:0]   free_blocks;
   } result_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_ROOT,
      S_LAST,
      S_DN_START,
      S_DN_L,
      S_DN_R,
      S_POST,
      S_UP,
      S_UP_CMP,
      S_FIN
   } state_type;

endpackage
`default_nettype wire

>>> rtl/wfha_req_if.sv
// request channel of the allocator
`default_nettype none
interface wfha_req_if;
   import wfha_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SIZE_W-1:0]   request_size;
   logic [ADDR_W-1:0]   user_address;
   logic [SIZE_W-1:0]   stored_size;
   logic                was_allocated;

   modport source (output valid, kind, request_size, user_address, stored_size,
                   was_allocated, input ready);
   modport sink (input valid, kind, request_size, user_address, stored_size,
                 was_allocated, output ready);
endinterface
`default_nettype wire

>>> rtl/wfha_rsp_if.sv
// response channel of the allocator
`default_nettype none
interface wfha_rsp_if;
   import wfha_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_address;
   logic [FREE_W-1:0]   free_blocks;

   modport source (output valid, status, result_address, free_blocks, input ready);
   modport sink (input valid, status, result_address, free_blocks, output ready);
endinterface
`default_nettype wire

>>> rtl/wfha_csr_if.sv
// register write channel of the allocator
`default_nettype none
interface wfha_csr_if;
   import wfha_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/wfha_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module wfha_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/wfha_csr.sv
// configuration registers of the allocator
`default_nettype none
module wfha_csr (
   input  wire logic    clock,
   input  wire logic    reset,
   wfha_csr_if.sink     csr_chan,
   output wfha_pkg::cfg_type cfg
);
   import wfha_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_BASE:   cfg_in.base_address = csr_chan.data;
            CSR_TOTAL:  cfg_in.region_bytes = csr_chan.data;
            CSR_HEADER: cfg_in.header_size  = csr_chan.data[HDR_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= BASE_RESET;
         cfg_ff.region_bytes <= TOTAL_RESET;
         cfg_ff.header_size  <= HEADER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> rtl/wfha_core.sv
// heap sequencer: pops, sifts and inserts free blocks in the heap ram
`default_nettype none
module wfha_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wfha_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire wfha_pkg::req_type    req_item,
   output logic                      res_valid,
   input  wire logic                 res_ready,
   output wfha_pkg::result_type      res
);
   import wfha_pkg::*;

   state_type            state_ff, state_in;
   req_type              item_ff, item_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   entry_type            held_ff, held_in;
   entry_type            best_ff, best_in;
   logic                 best_child_ff, best_child_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]     hole_ff, hole_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    need_ff, need_in;
   logic [ADDR_W-1:0]    baddr_ff, baddr_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ADDR_W-1:0]    raddr_ff, raddr_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_raw;
   entry_type            rd_entry;

   logic [CHILD_W-1:0]   l_idx, r_idx, count_ext;
   logic                 l_ok, r_ok;
   logic [IDX_W-1:0]     parent_idx;
   logic [SIZE_W:0]      need_sum, free_sum;
   logic [SIZE_W-1:0]    free_size;
   logic                 left_big, right_big;

   wfha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = rd_raw;

   // heap index arithmetic
   assign l_idx      = {hole_ff, 1'b1};
   assign r_idx      = l_idx + CHILD_W'(1);
   assign count_ext  = CHILD_W'(count_ff);
   assign l_ok       = l_idx < count_ext;
   assign r_ok       = r_idx < count_ext;
   assign parent_idx = (hole_ff - IDX_W'(1)) >> 1;

   // fit test and saturated free size
   assign need_sum  = {1'b0, item_ff.request_size} + (SIZE_W + 1)'(cfg.header_size);
   assign free_sum  = {1'b0, item_ff.stored_size} + (SIZE_W + 1)'(cfg.header_size);
   assign free_size = free_sum[SIZE_W] ? {SIZE_W{1'b1}} : free_sum[SIZE_W-1:0];

   // child compares, strictly larger wins
   assign left_big  = rd_entry.size > held_ff.size;
   assign right_big = rd_entry.size > best_ff.size;

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      best_idx_in   = best_idx_ff;
      hole_in       = hole_ff;
      rem_in        = rem_ff;
      need_in       = need_ff;
      baddr_in      = baddr_ff;
      status_in     = status_ff;
      raddr_in      = raddr_ff;
      wr_en         = 1'b0;
      wr_addr       = hole_ff;
      wr_data       = held_ff;
      rd_addr       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in   = req_item;
               status_in = STAT_OK;
               raddr_in  = '0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            // root read is issued here for an allocate
            rd_addr = '0;
            unique case (item_ff.kind)
               KIND_INIT: begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '{addr: cfg.base_address, size: cfg.region_bytes};
                  count_in = CNT_W'(1);
                  state_in = S_FIN;
               end
               KIND_ALLOC: begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_ROOT;
                  end
               end
               KIND_FREE: begin
                  priority if (item_ff.user_address == '0) begin
                     state_in = S_FIN;
                  end else if (!item_ff.was_allocated) begin
                     status_in = STAT_ISFREE;
                     state_in  = S_FIN;
                  end else if (count_ff == CNT_W'(HEAP_DEPTH)) begin
                     status_in = STAT_FULL;
                     state_in  = S_FIN;
                  end else begin
                     held_in.addr = item_ff.user_address - ADDR_W'(cfg.header_size);
                     held_in.size = free_size;
                     hole_in      = count_ff[IDX_W-1:0];
                     state_in     = S_UP;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end

         S_ROOT: begin
            if (need_sum > {1'b0, rd_entry.size}) begin
               status_in = STAT_SMALL;
               state_in  = S_FIN;
            end else begin
               need_in  = need_sum[SIZE_W-1:0];
               rem_in   = rd_entry.size - need_sum[SIZE_W-1:0];
               baddr_in = rd_entry.addr;
               raddr_in = rd_entry.addr + ADDR_W'(cfg.header_size);
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = S_POST;
               end else begin
                  // fetch the last entry to move into the root
                  rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                  state_in = S_LAST;
               end
            end
         end

         S_LAST: begin
            held_in  = rd_entry;
            hole_in  = '0;
            state_in = S_DN_START;
         end

         S_DN_START: begin
            if (l_ok) begin
               rd_addr  = l_idx[IDX_W-1:0];
               state_in = S_DN_L;
            end else begin
               wr_en    = 1'b1;
               state_in = S_POST;
            end
         end

         S_DN_L: begin
            best_in       = left_big ? rd_entry : held_ff;
            best_child_in = left_big;
            best_idx_in   = l_idx[IDX_W-1:0];
            if (r_ok) begin
               rd_addr  = r_idx[IDX_W-1:0];
               state_in = S_DN_R;
            end else if (left_big) begin
               // left child moves up into the hole
               wr_en    = 1'b1;
               wr_data  = rd_entry;
               hole_in  = l_idx[IDX_W-1:0];
               state_in = S_DN_START;
            end else begin
               wr_en    = 1'b1;
               state_in = S_POST;
            end
         end

         S_DN_R: begin
            priority if (right_big) begin
               wr_en    = 1'b1;
               wr_data  = rd_entry;
               hole_in  = r_idx[IDX_W-1:0];
               state_in = S_DN_START;
            end else if (best_child_ff) begin
               wr_en    = 1'b1;
               wr_data  = best_ff;
               hole_in  = best_idx_ff;
               state_in = S_DN_START;
            end else begin
               wr_en    = 1'b1;
               state_in = S_POST;
            end
         end

         S_POST: begin
            // put back a remainder larger than one header
            if (rem_ff > SIZE_W'(cfg.header_size)) begin
               held_in.addr = baddr_ff + need_ff;
               held_in.size = rem_ff;
               hole_in      = count_ff[IDX_W-1:0];
               state_in     = S_UP;
            end else begin
               state_in = S_FIN;
            end
         end

         S_UP: begin
            if (hole_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_FIN;
            end else begin
               rd_addr  = parent_idx;
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            if (held_ff.size <= rd_entry.size) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_FIN;
            end else begin
               // parent moves down into the hole
               wr_en    = 1'b1;
               wr_data  = rd_entry;
               hole_in  = parent_idx;
               state_in = S_UP;
            end
         end

         S_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      held_ff       <= held_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      best_idx_ff   <= best_idx_in;
      hole_ff       <= hole_in;
      rem_ff        <= rem_in;
      need_ff       <= need_in;
      baddr_ff      <= baddr_in;
      status_ff     <= status_in;
      raddr_ff      <= raddr_in;
   end

   assign res.status         = status_ff;
   assign res.result_address = raddr_ff;
   assign res.free_blocks    = FREE_W'(count_ff);

endmodule
`default_nettype wire

>>> rtl/worst_fit_heap_allocator.sv
// Worst-fit allocator: free blocks (address, size) sit in a 128-entry max-heap
// held in one synchronous ram with a registered read. One item is worked at a
// time. Init writes the whole region as the only free block. A free that is
// neither ignored nor refused climbs the heap from the last slot. An allocation
// that fits takes the root, sifts the last block down from the root, and then
// climbs a remainder larger than one header back into the heap. A finished
// result sits in an output register, so the next item is accepted while it
// waits to be taken. Registers are written through the csr channel, index 0
// base address, 1 region size, 2 header size.
`default_nettype none
module worst_fit_heap_allocator (
   input  wire logic clock,
   input  wire logic reset,
   wfha_req_if.sink   req_chan,
   wfha_rsp_if.source rsp_chan,
   wfha_csr_if.sink   csr_chan
);
   import wfha_pkg::*;

   cfg_type    cfg;
   req_type    req_item;
   result_type res;
   logic       res_valid;
   logic       res_ready;
   logic       core_ready;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   wfha_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // request item into the sequencer
   assign req_item.kind          = req_chan.kind;
   assign req_item.request_size  = req_chan.request_size;
   assign req_item.user_address  = req_chan.user_address;
   assign req_item.stored_size   = req_chan.stored_size;
   assign req_item.was_allocated = req_chan.was_allocated;
   assign req_chan.ready         = core_ready;

   wfha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_ready (core_ready),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register, refilled as soon as it empties
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.result_address = rsp_ff.result_address;
   assign rsp_chan.free_blocks    = rsp_ff.free_blocks;

endmodule
`default_nettype wire

>>> tb/tb_worst_fit_heap_allocator.sv
// testbench for the worst-fit heap allocator: random and directed items against a predictor
`default_nettype none
module tb_worst_fit_heap_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import wfha_pkg::*;

   // kind code with no operation behind it
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int MAX_REPORTS = 10;
   localparam int TAIL_CYCLES = 60;
   localparam int LIVE_MAX    = 256;

   // scoreboard: shadow heap, register copies and the queue of predicted results
   class alloc_scoreboard;
      logic [ADDR_W-1:0] base_addr;
      logic [SIZE_W-1:0] region_size;
      logic [HDR_W-1:0]  hdr_bytes;
      entry_type         blocks [HEAP_DEPTH];
      int unsigned       block_cnt;
      int unsigned       peak_cnt;
      result_type        due_q [$];
      longint            due_at_q [$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       status_seen [8];

      function new();
         base_addr   = BASE_RESET;
         region_size = TOTAL_RESET;
         hdr_bytes   = HEADER_RESET;
         block_cnt   = 0;
         peak_cnt    = 0;
         mismatches  = 0;
         checked     = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
         case (idx)
            CSR_BASE:   base_addr = val;
            CSR_TOTAL:  region_size = val;
            CSR_HEADER: hdr_bytes = val[HDR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      function void swap_blocks(int unsigned a, int unsigned b);
         entry_type t;
         t = blocks[a];
         blocks[a] = blocks[b];
         blocks[b] = t;
      endfunction

      // child moves above its parent only when strictly larger
      function void bubble_up(int unsigned i);
         int unsigned p;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (blocks[i].size <= blocks[p].size) break;
            swap_blocks(i, p);
            i = p;
         end
      endfunction

      function void settle_down(int unsigned i);
         int unsigned big;
         int unsigned l;
         int unsigned r;
         forever begin
            big = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < block_cnt && blocks[l].size > blocks[big].size) big = l;
            if (r < block_cnt && blocks[r].size > blocks[big].size) big = r;
            if (big == i) break;
            swap_blocks(i, big);
            i = big;
         end
      endfunction

      // returns 0 when the heap is already full
      function bit push_block(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
         if (block_cnt >= HEAP_DEPTH) return 1'b0;
         blocks[block_cnt].addr = a;
         blocks[block_cnt].size = s;
         bubble_up(block_cnt);
         block_cnt++;
         if (block_cnt > peak_cnt) peak_cnt = block_cnt;
         return 1'b1;
      endfunction

      function void take_root();
         block_cnt--;
         blocks[0] = blocks[block_cnt];
         settle_down(0);
      endfunction

      // work out the result of one accepted item and queue it
      function result_type note_request(req_type r, longint stamp);
         result_type        res;
         logic [SIZE_W:0]   need;
         logic [SIZE_W:0]   grown;
         logic [SIZE_W-1:0] rest;
         entry_type         top;
         res = '0;
         res.status = STAT_OK;
         case (r.kind)
            KIND_INIT: begin
               block_cnt = 0;
               void'(push_block(base_addr, region_size));
            end
            KIND_ALLOC: begin
               if (block_cnt == 0) begin
                  res.status = STAT_EMPTY;
               end else begin
                  // fit test without wrap, header included
                  need = {1'b0, r.request_size} + {{(SIZE_W + 1 - HDR_W){1'b0}}, hdr_bytes};
                  top = blocks[0];
                  if (need > {1'b0, top.size}) begin
                     res.status = STAT_SMALL;
                  end else begin
                     take_root();
                     res.result_address = top.addr + {{(ADDR_W - HDR_W){1'b0}}, hdr_bytes};
                     rest = top.size - need[SIZE_W-1:0];
                     if (rest > {{(SIZE_W - HDR_W){1'b0}}, hdr_bytes})
                        void'(push_block(top.addr + need[SIZE_W-1:0], rest));
                  end
               end
            end
            KIND_FREE: begin
               // null address is ignored
               if (r.user_address != '0) begin
                  if (!r.was_allocated) begin
                     res.status = STAT_ISFREE;
                  end else begin
                     grown = {1'b0, r.stored_size} + {{(SIZE_W + 1 - HDR_W){1'b0}}, hdr_bytes};
                     if (grown[SIZE_W]) grown[SIZE_W-1:0] = '1;
                     if (!push_block(r.user_address - {{(ADDR_W - HDR_W){1'b0}}, hdr_bytes},
                                     grown[SIZE_W-1:0]))
                        res.status = STAT_FULL;
                  end
               end
            end
            default: ;
         endcase
         res.free_blocks = FREE_W'(block_cnt);
         due_q.push_back(res);
         due_at_q.push_back(stamp);
         return res;
      endfunction

      function void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
      endfunction

      // compare one taken result with the oldest expectation
      function void check_result(result_type got, longint now);
         result_type want;
         checked++;
         if (due_q.size() == 0 || due_at_q[0] >= now) begin
            log_mismatch("result with nothing outstanding", '0, {29'b0, got.status});
            return;
         end
         want = due_q.pop_front();
         void'(due_at_q.pop_front());
         status_seen[want.status]++;
         if (got.status !== want.status)
            log_mismatch("status", {29'b0, want.status}, {29'b0, got.status});
         if (got.result_address !== want.result_address)
            log_mismatch("result_address", want.result_address, got.result_address);
         if (got.free_blocks !== want.free_blocks)
            log_mismatch("free_blocks", {24'b0, want.free_blocks}, {24'b0, got.free_blocks});
      endfunction
   endclass

   logic clock;
   logic reset;

   wfha_req_if req_chan ();
   wfha_rsp_if rsp_chan ();
   wfha_csr_if csr_chan ();

   worst_fit_heap_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   alloc_scoreboard board = new();
   bit              sender_idles;
   bit              receiver_stalls;
   int unsigned     items_sent;
   result_type      rsp_item;
   int unsigned     leftover;
   // addresses handed out and still held, with the size asked for
   logic [ADDR_W-1:0] live_addr_q [$];
   logic [SIZE_W-1:0] live_size_q [$];

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("[worst_fit_heap_allocator] ERROR");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_item.status         = rsp_chan.status;
         rsp_item.result_address = rsp_chan.result_address;
         rsp_item.free_blocks    = rsp_chan.free_blocks;
         board.check_result(rsp_item, $time);
      end
   end

   // result receiver with random stall bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic req_type make_item(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] rq,
                                         logic [ADDR_W-1:0] ua, logic [SIZE_W-1:0] ss,
                                         logic wa);
      req_type r;
      r.kind          = k;
      r.request_size  = rq;
      r.user_address  = ua;
      r.stored_size   = ss;
      r.was_allocated = wa;
      return r;
   endfunction

   // random item; frees mostly return a block handed out earlier
   function automatic req_type pick_item(int unsigned free_pct, int unsigned init_pct);
      req_type     r;
      int unsigned roll;
      int unsigned slot;
      r = make_item(KIND_ALLOC, $urandom, $urandom, $urandom, 1'b1);
      roll = $urandom_range(0, 99);
      if (roll < init_pct) begin
         r.kind = KIND_INIT;
      end else if (roll < init_pct + 3) begin
         r.kind = KIND_NONE;
      end else if (roll < init_pct + 3 + free_pct) begin
         r.kind = KIND_FREE;
         roll = $urandom_range(0, 9);
         if (roll < 7 && live_addr_q.size() > 0) begin
            slot = $urandom_range(0, live_addr_q.size() - 1);
            r.user_address = live_addr_q[slot];
            r.stored_size  = live_size_q[slot];
            live_addr_q.delete(slot);
            live_size_q.delete(slot);
         end else if (roll == 7) begin
            r.user_address = '0;
         end else if (roll == 8) begin
            r.was_allocated = 1'b0;
         end
      end else begin
         // sizes mostly small, now and then anywhere in range
         roll = $urandom_range(0, 9);
         if (roll < 6) r.request_size = $urandom_range(0, 512);
         else if (roll < 9) r.request_size = $urandom_range(0, 65536);
      end
      return r;
   endfunction

   // drive one item and wait for it to be taken
   task automatic send_item(input req_type r);
      result_type res;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= r.kind;
      req_chan.request_size  <= r.request_size;
      req_chan.user_address  <= r.user_address;
      req_chan.stored_size   <= r.stored_size;
      req_chan.was_allocated <= r.was_allocated;
      do @(posedge clock); while (!req_chan.ready);
      res = board.note_request(r, $time);
      items_sent++;
      if (r.kind == KIND_ALLOC && res.status == STAT_OK && live_addr_q.size() < LIVE_MAX) begin
         live_addr_q.push_back(res.result_address);
         live_size_q.push_back(r.request_size);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      board.set_register(idx, val);
   endtask

   task automatic configure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] total,
                            input logic [HDR_W-1:0] hdr);
      write_register(CSR_BASE, base);
      write_register(CSR_TOTAL, total);
      write_register(CSR_HEADER, {24'b0, hdr});
      csr_chan.valid <= 1'b0;
   endtask

   // stop sending and wait for every predicted result
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned free_pct,
                            input int unsigned init_pct);
      send_item(make_item(KIND_INIT, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1))));
      repeat (count) send_item(pick_item(free_pct, init_pct));
   endtask

   // main sequence
   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.kind          <= KIND_INIT;
      req_chan.request_size  <= '0;
      req_chan.user_address  <= '0;
      req_chan.stored_size   <= '0;
      req_chan.was_allocated <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= CSR_BASE;
      csr_chan.data          <= '0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      items_sent      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings: empty heap, ignored and refused frees
      send_item(make_item(KIND_ALLOC, 32'd100, '0, '0, 1'b1));
      send_item(make_item(KIND_FREE, 32'd5, '0, 32'd64, 1'b1));
      send_item(make_item(KIND_FREE, 32'd5, 32'h0000_1000, 32'd64, 1'b0));
      send_item(make_item(KIND_NONE, '1, '1, '1, 1'b1));
      // too large, remainder equal to the header, one byte more, exact fit
      send_item(make_item(KIND_INIT, '0, '0, '0, 1'b0));
      send_item(make_item(KIND_ALLOC, 32'hFFFF_FFFF, '0, '0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd1048528, '0, '0, 1'b1));
      send_item(make_item(KIND_INIT, '0, '0, '0, 1'b0));
      send_item(make_item(KIND_ALLOC, 32'd1048527, '0, '0, 1'b1));
      send_item(make_item(KIND_INIT, '0, '0, '0, 1'b0));
      send_item(make_item(KIND_ALLOC, 32'd1048552, '0, '0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd0, '0, '0, 1'b1));
      // equal sizes, then saturating and wrapping frees
      send_item(make_item(KIND_FREE, '0, 32'h0010_0000, 32'd1000, 1'b1));
      send_item(make_item(KIND_FREE, '0, 32'h0020_0000, 32'd1000, 1'b1));
      send_item(make_item(KIND_FREE, '0, 32'h0030_0000, 32'd1000, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd1000, '0, '0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd976, '0, '0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd0, '0, '0, 1'b1));
      send_item(make_item(KIND_FREE, '0, 32'h0040_0000, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(KIND_FREE, '0, 32'h0000_0010, 32'd0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'hFFFF_FFE7, '0, '0, 1'b1));
      send_item(make_item(KIND_ALLOC, 32'd2000, '0, '0, 1'b1));

      // random phases over several register settings
      run_phase(200, 45, 2);
      wait_idle();
      configure(32'hFFFF_F000, 32'hFFFF_FFFF, 8'd255);
      run_phase(180, 45, 2);
      wait_idle();
      // zero header and no reinit, so the heap fills up
      configure(32'h0000_1000, 32'h0001_0000, 8'd0);
      run_phase(220, 72, 0);
      wait_idle();
      configure($urandom, 32'd0, 8'($urandom_range(1, 254)));
      run_phase(150, 50, 3);
      wait_idle();
      // closing stretch at full rate on both sides
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      configure(32'd0, $urandom_range(4096, 32'h0100_0000), 8'd8);
      run_phase(160, 45, 1);
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      leftover = board.pending();
      $display("covered %0d items over five register settings, %0d results taken,",
               items_sent, board.checked);
      $display("peak %0d free blocks; status mix: ok %0d, empty %0d, too small %0d, %s %0d, %s %0d",
               board.peak_cnt, board.status_seen[STAT_OK], board.status_seen[STAT_EMPTY],
               board.status_seen[STAT_SMALL], "list full", board.status_seen[STAT_FULL],
               "already free", board.status_seen[STAT_ISFREE]);
      if (board.mismatches == 0 && leftover == 0) begin
         $display("[worst_fit_heap_allocator] OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", board.mismatches, leftover);
         $display("[worst_fit_heap_allocator] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
